FILE: src/cka_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell-keyed energy accumulator: shared types
// Beat payloads for the input and result channels, and the sequencer states.
// ----------------------------------------------------------------------------
package cka_pkg;

  // Table selection carried in the command field.
  localparam logic CMD_ENERGY = 1'b0;
  localparam logic CMD_PHOTON = 1'b1;

  typedef struct packed {
    logic        command;
    logic [63:0] cell_id;
    logic [23:0] energy;
  } cka_in_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic [31:0] total;
    logic        created;
    logic        full_res;
  } cka_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAST,
    ST_SCAN,
    ST_UPD
  } cka_state_e;

endpackage

FILE: src/cka_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell-keyed energy accumulator: table storage
// Key memory and sum memory for both tables, each with one write port and one
// registered read port. The top bit of the address selects the table.
// ----------------------------------------------------------------------------
module cka_store #(
  parameter int KEY_BITS = 64,
  parameter int SUM_BITS = 32,
  parameter int ADDR_W   = 9
) (
  input  logic                clk_i,
  input  logic                key_rd_en_i,
  input  logic [ADDR_W-1:0]   key_rd_addr_i,
  output logic [KEY_BITS-1:0] key_rd_data_o,
  input  logic                key_we_i,
  input  logic [ADDR_W-1:0]   key_wr_addr_i,
  input  logic [KEY_BITS-1:0] key_wr_data_i,
  input  logic                sum_rd_en_i,
  input  logic [ADDR_W-1:0]   sum_rd_addr_i,
  output logic [SUM_BITS-1:0] sum_rd_data_o,
  input  logic                sum_we_i,
  input  logic [ADDR_W-1:0]   sum_wr_addr_i,
  input  logic [SUM_BITS-1:0] sum_wr_data_i
);

  localparam int MemDepth = 1 << ADDR_W;

  logic [KEY_BITS-1:0] key_mem [MemDepth];
  logic [SUM_BITS-1:0] sum_mem [MemDepth];

  always_ff @(posedge clk_i) begin
    if (key_we_i) begin
      key_mem[key_wr_addr_i] <= key_wr_data_i;
    end
    if (key_rd_en_i) begin
      key_rd_data_o <= key_mem[key_rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we_i) begin
      sum_mem[sum_wr_addr_i] <= sum_wr_data_i;
    end
    if (sum_rd_en_i) begin
      sum_rd_data_o <= sum_mem[sum_rd_addr_i];
    end
  end

endmodule

FILE: src/cell_keyed_energy_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell-keyed energy accumulator
// Accumulates energy deposits and photon counts per detector cell in two
// keyed tables, with a last-hit cache in front of a linear slot search.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat (in_valid_i/in_ready_o) carries a command, a cell id and an
//   energy in keV. Command 0 adds the energy to the energy table, command 1
//   adds one to the photon table. Each input beat yields exactly one result
//   beat (out_valid_o/out_ready_i) with the slot, the saturated total, a
//   created flag, and full_res when the table was full and the beat dropped.
//   The block works on one beat at a time. As it takes a beat it reads the key
//   of the cached slot; when that slot matches or the table is empty, it goes
//   straight to the update step, else it first searches the filled slots from
//   slot 0 (one key memory read per cycle) until a match or the last slot.
//   The update step writes the sum unless the beat is dropped, and registers
//   the result beat. A new beat is taken as soon as the sequencer is idle,
//   even while the previous result waits in the output register; if the
//   receiver stalls, the next result waits in the update step until the
//   register frees. Reset empties both tables at once by clearing their fill
//   counts; no clearing pass is needed, as only filled slots are ever matched.
// ----------------------------------------------------------------------------
module cell_keyed_energy_accumulator #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS    = 64,
  parameter int SUM_BITS    = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cka_pkg::cka_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cka_pkg::cka_out_t out_data_o
);
  import cka_pkg::*;

  localparam int IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FillW = IdxW + 1;
  localparam int AddrW = IdxW + 1;

  cka_state_e state_q, state_d;

  logic                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [SUM_BITS-1:0]   add_q;
  logic [IdxW-1:0]       scan_idx_q, scan_idx_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  created_q, created_d;
  logic                  full_q, full_d;
  logic [1:0][FillW-1:0] fill_q;
  logic [1:0][IdxW-1:0]  last_q;
  logic                  out_valid_q;
  cka_out_t              out_q;

  // Memory ports.
  logic                key_rd_en, key_we, sum_rd_en, sum_we;
  logic [AddrW-1:0]    key_rd_addr, key_wr_addr, sum_rd_addr, sum_wr_addr;
  logic [KEY_BITS-1:0] key_rd_data;
  logic [SUM_BITS-1:0] sum_rd_data, sum_wr_data;

  // Lookup decisions.
  logic [FillW-1:0]    fill_cur;
  logic [IdxW-1:0]     last_cur;
  logic                key_match, last_hit, scan_hit, scan_end;
  logic                hit, miss, table_full, out_free, retire;
  logic [IdxW-1:0]     hit_idx;
  logic [FillW-1:0]    scan_next;

  // Update arithmetic.
  logic [SUM_BITS-1:0] old_sum, new_sum;
  logic [SUM_BITS:0]   sum_ext;
  logic [SUM_BITS+23:0] energy_ext;
  logic [SUM_BITS+31:0] total_ext;
  logic [IdxW+7:0]      slot_ext;

  cka_store #(
    .KEY_BITS (KEY_BITS),
    .SUM_BITS (SUM_BITS),
    .ADDR_W   (AddrW)
  ) u_store (
    .clk_i         (clk_i),
    .key_rd_en_i   (key_rd_en),
    .key_rd_addr_i (key_rd_addr),
    .key_rd_data_o (key_rd_data),
    .key_we_i      (key_we),
    .key_wr_addr_i (key_wr_addr),
    .key_wr_data_i (key_q),
    .sum_rd_en_i   (sum_rd_en),
    .sum_rd_addr_i (sum_rd_addr),
    .sum_rd_data_o (sum_rd_data),
    .sum_we_i      (sum_we),
    .sum_wr_addr_i (sum_wr_addr),
    .sum_wr_data_i (sum_wr_data)
  );

  assign fill_cur   = fill_q[cmd_q];
  assign last_cur   = last_q[cmd_q];
  assign key_match  = (key_rd_data == key_q);
  assign scan_next  = {1'b0, scan_idx_q} + FillW'(1);
  assign table_full = (fill_cur == FillW'(TABLE_DEPTH));
  assign out_free   = !out_valid_q || out_ready_i;

  // The cached slot only counts while it lies below the fill count.
  assign last_hit = (state_q == ST_LAST) && ({1'b0, last_cur} < fill_cur) && key_match;
  assign scan_hit = (state_q == ST_SCAN) && key_match;
  assign scan_end = (scan_next == fill_cur);
  assign hit      = last_hit || scan_hit;
  assign hit_idx  = (state_q == ST_LAST) ? last_cur : scan_idx_q;
  assign miss     = ((state_q == ST_LAST) && !last_hit && (fill_cur == '0)) ||
                    ((state_q == ST_SCAN) && !key_match && scan_end);
  assign retire   = (state_q == ST_UPD) && out_free;

  // Saturating add; a fresh entry starts from zero.
  assign old_sum     = created_q ? '0 : sum_rd_data;
  assign sum_ext     = {1'b0, old_sum} + {1'b0, add_q};
  assign new_sum     = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
  assign sum_wr_data = new_sum;
  assign energy_ext  = {{SUM_BITS{1'b0}}, in_data_i.energy};
  assign total_ext   = {32'b0, new_sum};
  assign slot_ext    = {8'b0, idx_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LAST;
      end
      ST_LAST: begin
        if (last_hit || miss) state_d = ST_UPD;
        else                  state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || miss) state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    key_rd_en   = 1'b0;
    key_rd_addr = {cmd_q, scan_next[IdxW-1:0]};
    key_we      = 1'b0;
    key_wr_addr = {cmd_q, fill_cur[IdxW-1:0]};
    sum_rd_en   = 1'b0;
    sum_rd_addr = {cmd_q, hit_idx};
    sum_we      = 1'b0;
    sum_wr_addr = {cmd_q, idx_q};
    scan_idx_d  = scan_idx_q;
    idx_d       = idx_q;
    created_d   = created_q;
    full_d      = full_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        key_rd_en   = in_valid_i;
        key_rd_addr = {in_data_i.command, last_q[in_data_i.command]};
      end
      ST_LAST, ST_SCAN: begin
        if (hit) begin
          sum_rd_en = 1'b1;
          idx_d     = hit_idx;
          created_d = 1'b0;
          full_d    = 1'b0;
        end else if (miss) begin
          key_we    = !table_full;
          idx_d     = fill_cur[IdxW-1:0];
          created_d = !table_full;
          full_d    = table_full;
        end else if (state_q == ST_LAST) begin
          key_rd_en   = 1'b1;
          key_rd_addr = {cmd_q, {IdxW{1'b0}}};
          scan_idx_d  = '0;
        end else begin
          key_rd_en  = 1'b1;
          scan_idx_d = scan_next[IdxW-1:0];
        end
      end
      ST_UPD: begin
        sum_we = out_free && !full_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (key_we) begin
        fill_q[cmd_q] <= fill_cur + FillW'(1);
      end
      if (retire && !full_q) begin
        last_q[cmd_q] <= idx_q;
      end
      if (retire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= in_data_i.command;
      key_q <= in_data_i.cell_id[KEY_BITS-1:0];
      add_q <= (in_data_i.command == CMD_PHOTON) ? SUM_BITS'(1) : energy_ext[SUM_BITS-1:0];
    end
    scan_idx_q <= scan_idx_d;
    idx_q      <= idx_d;
    created_q  <= created_d;
    full_q     <= full_d;
    if (retire) begin
      if (full_q) begin
        out_q <= '{slot: 8'b0, total: 32'b0, created: 1'b0, full_res: 1'b1};
      end else begin
        out_q <= '{slot: slot_ext[7:0], total: total_ext[31:0],
                   created: created_q, full_res: 1'b0};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A table never holds more entries than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[0] <= FillW'(TABLE_DEPTH)) && (fill_q[1] <= FillW'(TABLE_DEPTH)))
    else $error("fill count beyond table depth");

  // The cached slot always points at a filled entry once the table holds any.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[cmd_q] != '0) |-> ({1'b0, last_q[cmd_q]} < fill_q[cmd_q]))
    else $error("cached slot beyond fill count");

  // The search never presents a slot outside the filled region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ({1'b0, scan_idx_q} < fill_cur))
    else $error("search index beyond fill count");

  // A dropped beat leaves the sums untouched and still produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    retire && full_q |=> out_valid_q && out_q.full_res && !$past(sum_we))
    else $error("dropped beat handled wrongly");

endmodule
